// ----- hw/rtl/assert_macros.svh -----
// Assertion shorthands shared by the classifier RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/slc_pkg.sv -----
// Shared types, constants and line-finish logic for the source line classifier.
// No dependencies; used by slc_line_step and source_line_classifier_core.
package slc_pkg;

	localparam int MARKER_BYTES = 4;
	localparam int NUM_MARKERS  = 3;
	localparam int MARKER_W     = 32;
	localparam int MARKER_SLOTS = MARKER_W / 8;
	localparam int SLOT_W       = $clog2(MARKER_SLOTS);
	localparam int POS_W        = $clog2(MARKER_BYTES + 1);
	localparam int LEN_W        = 3;
	localparam int CNT_W        = 32;
	localparam int BYTES_W      = 48;
	localparam int CFG_IDX_W    = 3;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_MARKER      = 3'd0,
		REG_LINE_MARKER_LEN  = 3'd1,
		REG_OPEN_MARKER      = 3'd2,
		REG_OPEN_MARKER_LEN  = 3'd3,
		REG_CLOSE_MARKER     = 3'd4,
		REG_CLOSE_MARKER_LEN = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [MARKER_W-1:0] line_marker;
		logic [LEN_W-1:0]    line_marker_len;
		logic [MARKER_W-1:0] open_marker;
		logic [LEN_W-1:0]    open_marker_len;
		logic [MARKER_W-1:0] close_marker;
		logic [LEN_W-1:0]    close_marker_len;
	} cfg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       byte_present;
		logic       end_of_file;
	} src_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]   line_total;
		logic [CNT_W-1:0]   blank_total;
		logic [CNT_W-1:0]   comment_lines;
		logic [CNT_W-1:0]   code_total;
		logic [BYTES_W-1:0] byte_count;
	} res_item_t;

	typedef struct packed {
		logic                   in_block_comment;
		logic                   line_open;
		logic                   past_indent;
		logic [POS_W-1:0]       match_pos;
		logic [NUM_MARKERS-1:0] match_alive;
		logic [CNT_W-1:0]       total_count;
		logic [CNT_W-1:0]       blank_count;
		logic [CNT_W-1:0]       comment_count;
		logic [BYTES_W-1:0]     bytes_seen;
	} line_state_t;

	typedef struct packed {
		logic [1:0] comment_inc;
		logic       in_block;
	} finish_t;

	function automatic logic [POS_W-1:0] eff_len(logic [LEN_W-1:0] len);
		if (int'(len) > MARKER_BYTES)
			return POS_W'(MARKER_BYTES);
		return POS_W'(len);
	endfunction

	// bytes past the 32-bit register read as zero
	function automatic logic [7:0] marker_byte(logic [MARKER_W-1:0] val, logic [POS_W-1:0] pos);
		if (int'(pos) >= MARKER_SLOTS)
			return 8'h00;
		return val[8*pos[SLOT_W-1:0] +: 8];
	endfunction

	function automatic logic marker_hit(logic [POS_W-1:0] len, logic alive, logic [POS_W-1:0] pos);
		return (len == '0) || (alive && (pos >= len));
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [1:0] inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, v} + (CNT_W+1)'(inc);
		if (sum[CNT_W])
			return '1;
		return sum[CNT_W-1:0];
	endfunction

	// comment count update at the end of a non-blank line; the block
	// flag counts the line again whenever it is left set
	function automatic finish_t finish_line(cfg_t cfg, logic [NUM_MARKERS-1:0] alive,
		logic [POS_W-1:0] pos, logic in_blk);
		finish_t          r;
		logic [POS_W-1:0] l0;
		logic [POS_W-1:0] l1;
		logic [POS_W-1:0] l2;
		logic             h0;
		logic             h1;
		logic             h2;
		l0 = eff_len(cfg.line_marker_len);
		l1 = eff_len(cfg.open_marker_len);
		l2 = eff_len(cfg.close_marker_len);
		h0 = marker_hit(l0, alive[0], pos);
		h1 = marker_hit(l1, alive[1], pos);
		h2 = marker_hit(l2, alive[2], pos);
		r.comment_inc = 2'd0;
		r.in_block = in_blk;
		if (l0 != '0 && h0)
			r.comment_inc = r.comment_inc + 2'd1;
		if (l1 != '0) begin
			if (!in_blk) begin
				if (h1)
					r.in_block = 1'b1;
			end else if (h2) begin
				r.comment_inc = r.comment_inc + 2'd1;
				r.in_block = 1'b0;
			end
		end
		if (r.in_block)
			r.comment_inc = r.comment_inc + 2'd1;
		return r;
	endfunction

endpackage

// ----- hw/rtl/slc_line_step.sv -----
// Next-state logic for one present byte: indent skip, marker compare, line end.
// Depends on slc_pkg.
module slc_line_step (
	input  slc_pkg::cfg_t        cfg,
	input  slc_pkg::line_state_t cur,
	input  logic [7:0]           text_byte,
	output slc_pkg::line_state_t nxt
);

	logic [slc_pkg::MARKER_W-1:0]    mval [slc_pkg::NUM_MARKERS];
	logic [slc_pkg::POS_W-1:0]       mlen [slc_pkg::NUM_MARKERS];
	logic [slc_pkg::NUM_MARKERS-1:0] base_alive;
	logic [slc_pkg::POS_W-1:0]       base_pos;
	logic [slc_pkg::NUM_MARKERS-1:0] cmp_alive;
	logic [slc_pkg::POS_W-1:0]       cmp_pos;
	logic                            is_nl;
	logic                            is_skip;
	slc_pkg::finish_t                fin;

	assign mval[0] = cfg.line_marker;
	assign mval[1] = cfg.open_marker;
	assign mval[2] = cfg.close_marker;
	assign mlen[0] = slc_pkg::eff_len(cfg.line_marker_len);
	assign mlen[1] = slc_pkg::eff_len(cfg.open_marker_len);
	assign mlen[2] = slc_pkg::eff_len(cfg.close_marker_len);

	assign is_nl   = (text_byte == slc_pkg::CH_NEWLINE);
	assign is_skip = text_byte inside {slc_pkg::CH_SPACE, slc_pkg::CH_TAB, slc_pkg::CH_VT,
		slc_pkg::CH_FF, slc_pkg::CH_CR};

	// first compared byte of a line restarts every marker
	assign base_alive = cur.past_indent ? cur.match_alive : '1;
	assign base_pos   = cur.past_indent ? cur.match_pos : '0;

	always_comb begin
		cmp_alive = base_alive;
		for (int k = 0; k < slc_pkg::NUM_MARKERS; k++) begin
			if (base_pos < mlen[k] && text_byte != slc_pkg::marker_byte(mval[k], base_pos))
				cmp_alive[k] = 1'b0;
		end
		if (int'(base_pos) < slc_pkg::MARKER_BYTES)
			cmp_pos = base_pos + 1'b1;
		else
			cmp_pos = base_pos;
	end

	assign fin = slc_pkg::finish_line(cfg, cmp_alive, cmp_pos, cur.in_block_comment);

	always_comb begin
		nxt = cur;
		if (cur.bytes_seen != '1)
			nxt.bytes_seen = cur.bytes_seen + 1'b1;
		nxt.line_open = 1'b1;
		if (is_nl) begin
			nxt.total_count = slc_pkg::sat_add(cur.total_count, 2'd1);
			if (!cur.past_indent && !cur.in_block_comment) begin
				nxt.blank_count = slc_pkg::sat_add(cur.blank_count, 2'd1);
			end else begin
				nxt.comment_count    = slc_pkg::sat_add(cur.comment_count, fin.comment_inc);
				nxt.in_block_comment = fin.in_block;
			end
			nxt.line_open   = 1'b0;
			nxt.past_indent = 1'b0;
			nxt.match_pos   = '0;
			nxt.match_alive = '0;
		end else if (cur.past_indent || !is_skip) begin
			nxt.past_indent = 1'b1;
			nxt.match_alive = cmp_alive;
			nxt.match_pos   = cmp_pos;
		end
	end

endmodule

// ----- hw/rtl/source_line_classifier_core.sv -----
// Source line classifier top level: config registers, per-byte state, result pipeline.
// Depends on slc_pkg, slc_line_step and assert_macros.svh.
//
// Usage:
//   src channel: one word per file byte (text_byte, byte_present, end_of_file).
//     A word with end_of_file set closes the file; its byte, if present,
//     is counted first. A word with neither flag set is a no-op.
//   res channel: one word per file with total, blank, comment, code and
//     byte counts; code is total minus comment minus blank, floored at zero.
//   cfg channel: cfg_index selects the register (marker bytes or lengths),
//     cfg_data carries the value; cfg_ready is always high. Write only while
//     no file is in progress and no result is outstanding.
// Throughput: one src word per cycle while no end-of-file word is held waiting;
// the per-byte update is a combinational loop on the line state register.
// Result path: input register, end-of-line finish stage, code subtract stage
// into the output register.
// Reset clears the line state, the pipeline and all config registers.
// A stalled res side holds the result; non-final bytes keep streaming and
// only another end-of-file word waits once the three result stages are full.
module source_line_classifier_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 src_valid,
	output logic                                 src_ready,
	input  slc_pkg::src_item_t                   src_item,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output slc_pkg::res_item_t                   res_item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [slc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [slc_pkg::MARKER_W-1:0]         cfg_data
);

	`include "assert_macros.svh"

	slc_pkg::cfg_t        cfg_q;
	slc_pkg::line_state_t state_q;
	slc_pkg::line_state_t step_nxt;
	slc_pkg::line_state_t post_state;

	logic                 v_s1;
	slc_pkg::src_item_t   item_s1;
	logic                 s1_take;

	logic                 v_s2;
	slc_pkg::line_state_t snap_s2;
	logic                 s2_free;

	logic                 v_s3;
	logic [slc_pkg::CNT_W-1:0]   tot_s3;
	logic [slc_pkg::CNT_W-1:0]   blank_s3;
	logic [slc_pkg::CNT_W-1:0]   com_s3;
	logic [slc_pkg::BYTES_W-1:0] bytes_s3;
	logic                 s3_free;

	slc_pkg::finish_t     fin_s2;
	logic [slc_pkg::CNT_W-1:0]   tot_fin;
	logic [slc_pkg::CNT_W-1:0]   com_fin;
	logic [slc_pkg::CNT_W:0]     used_s3;
	logic [slc_pkg::CNT_W-1:0]   code_s3;

	logic                 res_valid_q;
	slc_pkg::res_item_t   res_item_q;
	logic                 res_free;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				slc_pkg::REG_LINE_MARKER:      cfg_q.line_marker      <= cfg_data;
				slc_pkg::REG_LINE_MARKER_LEN:  cfg_q.line_marker_len  <= cfg_data[slc_pkg::LEN_W-1:0];
				slc_pkg::REG_OPEN_MARKER:      cfg_q.open_marker      <= cfg_data;
				slc_pkg::REG_OPEN_MARKER_LEN:  cfg_q.open_marker_len  <= cfg_data[slc_pkg::LEN_W-1:0];
				slc_pkg::REG_CLOSE_MARKER:     cfg_q.close_marker     <= cfg_data;
				slc_pkg::REG_CLOSE_MARKER_LEN: cfg_q.close_marker_len <= cfg_data[slc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain, output side first
	assign res_free  = !res_valid_q || res_ready;
	assign s3_free   = !v_s3 || res_free;
	assign s2_free   = !v_s2 || s3_free;
	assign s1_take   = v_s1 && (!item_s1.end_of_file || s2_free);
	assign src_ready = !v_s1 || s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (src_ready) begin
			v_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready)
			item_s1 <= src_item;
	end

	slc_line_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.text_byte (item_s1.text_byte),
		.nxt       (step_nxt)
	);

	assign post_state = item_s1.byte_present ? step_nxt : state_q;

	// line state: cleared for the next file once the end word moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_take) begin
			state_q <= item_s1.end_of_file ? '0 : post_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_take && item_s1.end_of_file;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_take && item_s1.end_of_file)
			snap_s2 <= post_state;
	end

	// an unfinished last line counts as a line and gets the marker check
	assign fin_s2  = slc_pkg::finish_line(cfg_q, snap_s2.match_alive, snap_s2.match_pos,
		snap_s2.in_block_comment);
	assign tot_fin = snap_s2.line_open ? slc_pkg::sat_add(snap_s2.total_count, 2'd1)
		: snap_s2.total_count;
	assign com_fin = snap_s2.line_open ? slc_pkg::sat_add(snap_s2.comment_count, fin_s2.comment_inc)
		: snap_s2.comment_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_free) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && v_s2) begin
			tot_s3   <= tot_fin;
			blank_s3 <= snap_s2.blank_count;
			com_s3   <= com_fin;
			bytes_s3 <= snap_s2.bytes_seen;
		end
	end

	assign used_s3 = {1'b0, com_s3} + {1'b0, blank_s3};
	assign code_s3 = (used_s3 >= {1'b0, tot_s3}) ? '0 : (tot_s3 - used_s3[slc_pkg::CNT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && v_s3) begin
			res_item_q.line_total    <= tot_s3;
			res_item_q.blank_total   <= blank_s3;
			res_item_q.comment_lines <= com_s3;
			res_item_q.code_total    <= code_s3;
			res_item_q.byte_count    <= bytes_s3;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	`ASSERT_ALWAYS(a_state_clear_after_eof,
		(s1_take && item_s1.end_of_file) |=> (state_q == '0),
		"line state not cleared after end of file")
	`ASSERT_NEVER(a_blank_le_total, state_q.blank_count > state_q.total_count,
		"blank count above total")
	`ASSERT_NEVER(a_indent_needs_open_line, state_q.past_indent && !state_q.line_open,
		"past indent on a closed line")
	`ASSERT_NEVER(a_match_pos_range, int'(state_q.match_pos) > slc_pkg::MARKER_BYTES,
		"match position out of range")
	`ASSERT_ALWAYS(a_code_le_total,
		res_valid_q |-> (res_item_q.code_total <= res_item_q.line_total),
		"code count above total")

endmodule

// ----- sim/tb_source_line_classifier_core.sv -----
// Testbench for source_line_classifier_core: streams generated source files byte by byte
// and checks each end-of-file count word against a line tally kept in the bench.
// Depends on slc_pkg and the classifier RTL only.
module tb_source_line_classifier_core;
	import slc_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASES      = 9;
	localparam int PHASE_WORDS = 178;

	// line tally: mirrors the per-file counting and queues the expected count words
	class line_tally;
		logic [MARKER_W-1:0] mark [NUM_MARKERS];
		logic [LEN_W-1:0]    mlen [NUM_MARKERS];
		logic                in_blk;
		logic                line_open;
		logic                past_indent;
		int unsigned         mpos;
		logic [2:0]          alive;
		logic [CNT_W-1:0]    total;
		logic [CNT_W-1:0]    blank;
		logic [CNT_W-1:0]    comment;
		logic [BYTES_W-1:0]  nbytes;
		res_item_t           expected_tallies [$];
		int                  errors;
		int                  files;

		function new();
			for (int k = 0; k < NUM_MARKERS; k++) begin
				mark[k] = '0;
				mlen[k] = '0;
			end
			errors = 0;
			files = 0;
			restart();
		endfunction

		function void next_line();
			line_open = 1'b0;
			past_indent = 1'b0;
			mpos = 0;
			alive = '0;
		endfunction

		function void restart();
			in_blk = 1'b0;
			next_line();
			total = '0;
			blank = '0;
			comment = '0;
			nbytes = '0;
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] v);
			case (idx)
				REG_LINE_MARKER:      mark[0] = v;
				REG_LINE_MARKER_LEN:  mlen[0] = v[LEN_W-1:0];
				REG_OPEN_MARKER:      mark[1] = v;
				REG_OPEN_MARKER_LEN:  mlen[1] = v[LEN_W-1:0];
				REG_CLOSE_MARKER:     mark[2] = v;
				REG_CLOSE_MARKER_LEN: mlen[2] = v[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff(int k);
			return (mlen[k] > MARKER_BYTES) ? MARKER_BYTES : mlen[k];
		endfunction

		function bit hit(int k);
			int unsigned l;
			l = eff(k);
			return (l == 0) || (alive[k] && mpos >= l);
		endfunction

		function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
			return (v == '1) ? v : v + 1'b1;
		endfunction

		function void compare(logic [7:0] b);
			for (int k = 0; k < NUM_MARKERS; k++) begin
				if (mpos < eff(k) && b != mark[k][8*mpos +: 8])
					alive[k] = 1'b0;
			end
			if (mpos < MARKER_BYTES)
				mpos++;
		endfunction

		// line marker, then block open/close; an open block counts the line once more
		function void end_line();
			if (eff(0) != 0 && hit(0))
				comment = bump(comment);
			if (eff(1) != 0) begin
				if (!in_blk) begin
					if (hit(1))
						in_blk = 1'b1;
				end else if (hit(2)) begin
					comment = bump(comment);
					in_blk = 1'b0;
				end
			end
			if (in_blk)
				comment = bump(comment);
		endfunction

		function void note_word(src_item_t w);
			logic [7:0]       b;
			logic             skip;
			logic [CNT_W+1:0] used;
			res_item_t        r;
			if (w.byte_present) begin
				b = w.text_byte;
				skip = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) ||
					(b == CH_FF) || (b == CH_CR);
				if (nbytes != '1)
					nbytes = nbytes + 1'b1;
				line_open = 1'b1;
				if (b == CH_NEWLINE) begin
					total = bump(total);
					if (!past_indent && !in_blk) begin
						blank = bump(blank);
					end else begin
						if (!past_indent) begin
							alive = '1;
							mpos = 0;
						end
						compare(b);
						end_line();
					end
					next_line();
				end else if (past_indent || !skip) begin
					if (!past_indent) begin
						past_indent = 1'b1;
						alive = '1;
						mpos = 0;
					end
					compare(b);
				end
			end
			if (w.end_of_file) begin
				if (line_open) begin
					total = bump(total);
					end_line();
				end
				used = {2'b00, comment} + {2'b00, blank};
				r.line_total = total;
				r.blank_total = blank;
				r.comment_lines = comment;
				r.code_total = (used >= {2'b00, total}) ? '0 : total - used[CNT_W-1:0];
				r.byte_count = nbytes;
				expected_tallies.push_back(r);
				restart();
			end
		endfunction

		function void report(string name, logic [BYTES_W-1:0] want, logic [BYTES_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_tally(res_item_t got);
			res_item_t want;
			if (expected_tallies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word, expected none, got %h", $time, got);
				return;
			end
			want = expected_tallies.pop_front();
			files++;
			report("line_total", want.line_total, got.line_total);
			report("blank_total", want.blank_total, got.blank_total);
			report("comment_lines", want.comment_lines, got.comment_lines);
			report("code_total", want.code_total, got.code_total);
			report("byte_count", want.byte_count, got.byte_count);
		endfunction

		function int pending();
			return expected_tallies.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  src_valid;
	logic                  src_ready;
	src_item_t             src_item;
	logic                  res_valid;
	logic                  res_ready;
	res_item_t             res_item;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [MARKER_W-1:0]   cfg_data;

	line_tally             board;
	logic [MARKER_W-1:0]   set_mark [NUM_MARKERS];
	logic [LEN_W-1:0]      set_len [NUM_MARKERS];
	src_item_t             file_words [$];
	int                    src_gap_pct;
	int                    res_stall_pct;
	bit                    hold_req;
	int                    word_total;
	int                    setting_total;
	int                    quiet;

	source_line_classifier_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic src_item_t mk_word(logic [7:0] b, logic present, logic eof);
		src_item_t w;
		w.text_byte = b;
		w.byte_present = present;
		w.end_of_file = eof;
		return w;
	endfunction

	function automatic void push_byte(logic [7:0] b);
		file_words.push_back(mk_word(b, 1'b1, 1'b0));
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_byte();
		int k;
		int p;
		k = $urandom_range(NUM_MARKERS - 1);
		p = $urandom_range(MARKER_SLOTS - 1);
		case ($urandom_range(5))
			0: return 8'($urandom);
			1, 2: return set_mark[k][8*p +: 8];
			default: return 8'h61 + 8'($urandom_range(3));
		endcase
	endfunction

	function automatic logic [7:0] marker_char();
		case ($urandom_range(7))
			0: return 8'h2F;
			1: return 8'h2A;
			2: return 8'h23;
			3: return 8'h2D;
			4: return CH_SPACE;
			5: return CH_NEWLINE;
			default: return 8'($urandom);
		endcase
	endfunction

	// indent, then maybe a (possibly cut short) marker, then a short tail
	function automatic void add_line(bit with_nl);
		int n;
		int k;
		int plen;
		n = ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(4))
				0: push_byte(CH_SPACE);
				1: push_byte(CH_TAB);
				2: push_byte(CH_VT);
				3: push_byte(CH_FF);
				default: push_byte(CH_CR);
			endcase
		end
		k = $urandom_range(5);
		if (!(k == 0 && with_nl)) begin
			if (k >= 1 && k <= NUM_MARKERS) begin
				plen = (set_len[k-1] > MARKER_BYTES) ? MARKER_BYTES : set_len[k-1];
				if (plen > 0 && $urandom_range(3) == 0)
					plen--;
				for (int p = 0; p < plen; p++)
					push_byte(set_mark[k-1][8*p +: 8]);
			end
			repeat ($urandom_range(4))
				push_byte(pick_byte());
		end
		if (with_nl)
			push_byte(CH_NEWLINE);
	endfunction

	function automatic void build_file();
		int        lines;
		bit        open_tail;
		src_item_t w;
		file_words.delete();
		if ($urandom_range(9) == 0) begin
			// raw noise: any byte, some words absent
			repeat ($urandom_range(1, 30))
				file_words.push_back(mk_word(8'($urandom), $urandom_range(9) != 0, 1'b0));
		end else begin
			lines = $urandom_range(0, 6);
			open_tail = ($urandom_range(3) == 0);
			for (int i = 0; i < lines; i++) begin
				add_line(!(open_tail && i == lines - 1));
				if ($urandom_range(7) == 0)
					file_words.push_back(mk_word(8'($urandom), 1'b0, 1'b0));
			end
		end
		if (file_words.size() != 0 && file_words[file_words.size()-1].byte_present &&
			$urandom_range(1) == 1) begin
			w = file_words.pop_back();
			w.end_of_file = 1'b1;
			file_words.push_back(w);
		end else begin
			file_words.push_back(mk_word(8'($urandom), 1'b0, 1'b1));
		end
	endfunction

	task automatic send_word(input src_item_t w);
		@(negedge clk);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= w;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		board.note_word(w);
		if (w.byte_present || w.end_of_file)
			word_total++;
	endtask

	task automatic send_file();
		foreach (file_words[i])
			send_word(file_words[i]);
	endtask

	task automatic cfg_write(input reg_index_t idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.write_reg(idx, data);
	endtask

	// length registers get random upper data bits; only the low bits count
	task automatic program_regs();
		cfg_write(REG_LINE_MARKER, set_mark[0]);
		cfg_write(REG_LINE_MARKER_LEN, {29'($urandom), set_len[0]});
		cfg_write(REG_OPEN_MARKER, set_mark[1]);
		cfg_write(REG_OPEN_MARKER_LEN, {29'($urandom), set_len[1]});
		cfg_write(REG_CLOSE_MARKER, set_mark[2]);
		cfg_write(REG_CLOSE_MARKER_LEN, {29'($urandom), set_len[2]});
		@(negedge clk);
		cfg_valid <= 1'b0;
		setting_total++;
	endtask

	// let the result words and the pipeline empty before touching registers
	task automatic drain();
		@(negedge clk);
		src_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			res_ready <= ($urandom_range(99) >= res_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			board.check_tally(res_item);
	end

	always @(posedge clk) begin
		if (arst_n && ((src_valid && src_ready) || (res_valid && res_ready) ||
			(cfg_valid && cfg_ready)))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
			$display("FAIL source_line_classifier_core");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_item = '0;
		res_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_LINE_MARKER;
		cfg_data = '0;
		hold_req = 1'b0;
		src_gap_pct = 31;
		res_stall_pct = 54;
		word_total = 0;
		setting_total = 0;
		quiet = 0;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: C-style markers "//", "/*", "*/"
		set_mark[0] = {16'($urandom), 8'h2F, 8'h2F};
		set_mark[1] = {16'($urandom), 8'h2A, 8'h2F};
		set_mark[2] = {16'($urandom), 8'h2F, 8'h2A};
		for (int k = 0; k < NUM_MARKERS; k++)
			set_len[k] = 3'd2;
		program_regs();
		file_words.delete();
		push_byte(CH_SPACE);
		push_byte(CH_TAB);
		push_byte(CH_VT);
		push_byte(CH_FF);
		push_byte(CH_CR);
		push_byte(CH_NEWLINE);
		push_text("//x\n");
		push_text("/*\n");
		push_text("b\n");
		push_text("*/\n");
		push_text("/\n");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_NEWLINE);
		file_words.push_back(mk_word(8'h5A, 1'b0, 1'b0));
		file_words.push_back(mk_word(8'h61, 1'b1, 1'b1));
		// empty file: a lone end word
		file_words.push_back(mk_word(8'hA5, 1'b0, 1'b1));
		send_file();
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 3)
				0: begin
					src_gap_pct = 31;
					res_stall_pct = 54;
				end
				1: begin
					src_gap_pct = 54;
					res_stall_pct = 31;
				end
				default: begin
					src_gap_pct = 0;
					res_stall_pct = 0;
				end
			endcase
			for (int k = 0; k < NUM_MARKERS; k++) begin
				case (ph)
					0: begin
						set_mark[k] = $urandom;
						set_len[k] = 3'd0;
					end
					1: begin
						set_mark[k] = '1;
						set_len[k] = 3'd7;
					end
					2: begin
						set_mark[k] = '0;
						set_len[k] = 3'd4;
					end
					default: begin
						set_mark[k] = {marker_char(), marker_char(), marker_char(), marker_char()};
						set_len[k] = 3'($urandom_range(7));
					end
				endcase
			end
			program_regs();
			if (ph == 6) begin
				// long result hold-off while short files keep coming
				hold_req = 1'b1;
				repeat (24) begin
					send_word(mk_word(pick_byte(), 1'b1, 1'b0));
					send_word(mk_word(CH_NEWLINE, 1'b1, 1'b1));
				end
			end
			while (word_total < 27 + (ph + 1) * PHASE_WORDS) begin
				build_file();
				send_file();
			end
			drain();
		end

		$display("Checked %0d files (%0d file words) under %0d register settings,",
			board.files, word_total, setting_total);
		$display("with sender/receiver stalls both ways, no stalls, and one long result hold-off.");
		if (board.errors == 0)
			$display("PASS source_line_classifier_core");
		else
			$display("FAIL source_line_classifier_core");
		$finish;
	end

endmodule
